FILE: hdl/crt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the three-congruence crt solver
// no dependencies; imported by every module of the block
package crt_pkg;

   localparam int LANE_COUNT = 3;
   localparam int MOD_W      = 16;
   localparam int COF_W      = 2 * MOD_W;
   localparam int SOL_W      = 3 * MOD_W;
   localparam int COEF_W     = MOD_W + 2;
   localparam int CNT_W      = $clog2(COF_W + 1);
   localparam int IDX_W      = $clog2(LANE_COUNT);

   typedef enum logic [2:0] {
      L_IDLE,
      L_COFMOD,
      L_CHECK,
      L_EUCDIV,
      L_PMSTART,
      L_PMOD,
      L_TERM,
      L_DONE
   } lane_state_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_COF,
      T_PROD,
      T_LANES,
      T_WAIT,
      T_MERGE,
      T_OUT
   } top_state_type;

   typedef struct packed {
      logic             done;
      logic             ok;
      logic [SOL_W-1:0] term;
   } lane_stat_type;

   typedef struct packed {
      logic             done;
      logic [COF_W-1:0] quotient;
      logic [MOD_W-1:0] remainder;
   } div_res_type;

endpackage

FILE: hdl/crt_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on crt_pkg
module crt_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [crt_pkg::COF_W-1:0] dividend,
   input  logic [crt_pkg::MOD_W-1:0] divisor,
   output crt_pkg::div_res_type      result
);
   import crt_pkg::*;

   logic [COF_W-1:0] quo_ff, quo_in;
   logic [MOD_W-1:0] rem_ff, rem_in;
   logic [MOD_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MOD_W:0]   shifted;
   logic [MOD_W:0]   diff;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[COF_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(COF_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[MOD_W-1:0] : shifted[MOD_W-1:0];
         quo_in = {quo_ff[COF_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

FILE: hdl/crt_lane.sv
`timescale 1ns / 1ps
// one congruence: cofactor inverse by extended euclid, then the crt term
// depends on crt_pkg and crt_div
module crt_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [crt_pkg::MOD_W-1:0] residue,
   input  logic [crt_pkg::MOD_W-1:0] modulus,
   input  logic [crt_pkg::COF_W-1:0] cofactor,
   output crt_pkg::lane_stat_type    status
);
   import crt_pkg::*;

   lane_state_type state_ff, state_in;
   logic [MOD_W-1:0]         r0_ff, r0_in, r1_ff, r1_in;
   logic signed [COEF_W-1:0] c0_ff, c0_in, c1_ff, c1_in;
   logic [MOD_W-1:0]         inv_ff, inv_in, t_ff, t_in;
   logic [SOL_W-1:0]         term_ff, term_in;
   logic                     ok_ff, ok_in;

   logic                       div_start;
   logic [COF_W-1:0]           div_dividend;
   logic [MOD_W-1:0]           div_divisor;
   div_res_type                div_res;
   logic signed [COEF_W-1:0]   q_s;
   logic signed [2*COEF_W-1:0] qc;
   logic signed [2*COEF_W-1:0] c_new;
   logic signed [COEF_W-1:0]   c_pos;
   logic [COEF_W-2:0]          c_wrap;

   crt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         L_IDLE, L_DONE: begin
            if (start) state_in = (modulus == '0) ? L_DONE : L_COFMOD;
         end
         L_COFMOD:  if (div_res.done) state_in = L_CHECK;
         L_CHECK: begin
            if (r1_ff != '0)      state_in = L_EUCDIV;
            else if (r0_ff != MOD_W'(1)) state_in = L_DONE;
            else                  state_in = L_PMSTART;
         end
         L_EUCDIV:  if (div_res.done) state_in = L_CHECK;
         L_PMSTART: state_in = L_PMOD;
         L_PMOD:    if (div_res.done) state_in = L_TERM;
         L_TERM:    state_in = L_DONE;
         default:   state_in = L_IDLE;
      endcase
   end

   // bezout update and inverse normalization
   always_comb begin
      q_s    = $signed({2'b00, div_res.quotient[MOD_W-1:0]});
      qc     = (2*COEF_W)'(q_s) * (2*COEF_W)'(c1_ff);
      c_new  = $signed({{COEF_W{c0_ff[COEF_W-1]}}, c0_ff}) - qc;
      c_pos  = c0_ff[COEF_W-1] ? c0_ff + $signed({2'b00, modulus}) : c0_ff;
      c_wrap = c_pos[COEF_W-2:0];
      if (c_wrap >= {1'b0, modulus}) c_wrap = c_wrap - {1'b0, modulus};
   end

   // datapath and divider control
   always_comb begin
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      inv_in       = inv_ff;
      t_in         = t_ff;
      term_in      = term_ff;
      ok_in        = ok_ff;
      div_start    = 1'b0;
      div_dividend = cofactor;
      div_divisor  = modulus;
      case (state_ff)
         L_IDLE, L_DONE: begin
            if (start) begin
               ok_in     = 1'b0;
               div_start = (modulus != '0);
            end
         end
         L_COFMOD: begin
            r0_in = modulus;
            r1_in = div_res.remainder;
            c0_in = '0;
            c1_in = COEF_W'(1);
         end
         L_CHECK: begin
            inv_in       = c_wrap[MOD_W-1:0];
            div_start    = (r1_ff != '0);
            div_dividend = {{(COF_W-MOD_W){1'b0}}, r0_ff};
            div_divisor  = r1_ff;
         end
         L_EUCDIV: begin
            if (div_res.done) begin
               r0_in = r1_ff;
               r1_in = div_res.remainder;
               c0_in = c1_ff;
               c1_in = c_new[COEF_W-1:0];
            end
         end
         L_PMSTART: begin
            div_start    = 1'b1;
            div_dividend = COF_W'(residue) * COF_W'(inv_ff);
         end
         L_PMOD: t_in = div_res.remainder;
         L_TERM: begin
            term_in = SOL_W'(cofactor) * SOL_W'(t_ff);
            ok_in   = 1'b1;
         end
         default: ok_in = ok_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      c0_ff   <= c0_in;
      c1_ff   <= c1_in;
      inv_ff  <= inv_in;
      t_ff    <= t_in;
      term_ff <= term_in;
      if (reset) begin
         state_ff <= L_IDLE;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
      end
   end

   assign status.done = (state_ff == L_DONE);
   assign status.ok   = ok_ff;
   assign status.term = term_ff;

endmodule

FILE: hdl/crt_merge.sv
`timescale 1ns / 1ps
// sums the lane terms modulo the modulus product, one term per cycle
// depends on crt_pkg
module crt_merge (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            start,
   input  crt_pkg::lane_stat_type [crt_pkg::LANE_COUNT-1:0] lanes,
   input  logic [crt_pkg::SOL_W-1:0]                       modulus_prod,
   output logic                                            done,
   output logic [crt_pkg::SOL_W-1:0]                       solution,
   output logic                                            solvable
);
   import crt_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SOL_W-1:0] sum_ff, sum_in;
   logic             ok_ff, ok_in;
   logic [SOL_W:0]   acc;

   always_comb begin
      acc     = {1'b0, sum_ff} + {1'b0, lanes[idx_ff].term};
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum_in  = sum_ff;
      ok_in   = ok_ff;
      if (start) begin
         idx_in  = '0;
         busy_in = 1'b1;
         sum_in  = '0;
         ok_in   = 1'b1;
      end else if (busy_ff) begin
         if (acc >= {1'b0, modulus_prod}) acc = acc - {1'b0, modulus_prod};
         sum_in = acc[SOL_W-1:0];
         ok_in  = ok_ff & lanes[idx_ff].ok;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == IDX_W'(LANE_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      ok_ff  <= ok_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign solvable = ok_ff;
   assign solution = ok_ff ? sum_ff : '0;

endmodule

FILE: hdl/crt_three_congruences_top.sv
`timescale 1ns / 1ps
// crt_three_congruences_top: solves x = residue_i mod modulus_i for three congruences
// depends on crt_pkg, crt_lane, crt_div and crt_merge
//
// usage
//   req channel: one transfer carries three residue/modulus pairs (16 bits each)
//   rsp channel: one transfer per request, solution in tdata, solvable flag in tuser
//   three lanes, one per congruence, each with its own bit-serial divider,
//   find the cofactor inverse by extended euclid side by side; a merge stage
//   then adds the three terms modulo the modulus product, one per cycle
// flow
//   cofactors, then the modulus product, are registered before the lanes
//   start; a lane runs 2 + (euclid steps) divides, and euclid steps on
//   16-bit values are at most 22; the merge waits for the slowest lane's
//   euclid loop; a zero modulus skips every divide and a gcd other than
//   one skips the last divide, so such a lane finishes its work sooner
//   one item is in work at a time; req_tready is high only when idle
// reset
//   synchronous, active high; clears all control state, rsp_tvalid drops
// stall
//   a finished result waits in the rsp output register; the next request
//   is accepted and worked on meanwhile, and its result waits for the slot
module crt_three_congruences_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // residue_0, modulus_0, residue_1, modulus_1, residue_2, modulus_2 from bit 0 up
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // solution
   output logic [47:0] rsp_tdata,
   // solvable
   output logic        rsp_tuser
);
   import crt_pkg::*;

   top_state_type state_ff, state_in;

   // latched request pairs
   logic [MOD_W-1:0] res_ff [LANE_COUNT];
   logic [MOD_W-1:0] mod_ff [LANE_COUNT];
   // cofactors and modulus product
   logic [COF_W-1:0] cof_ff [LANE_COUNT];
   logic [COF_W-1:0] cof_in [LANE_COUNT];
   logic [SOL_W-1:0] prod_ff, prod_in;

   // output slot
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SOL_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_user_ff, rsp_user_in;

   logic                                  req_xfer;
   logic                                  lane_start;
   logic                                  merge_start;
   logic                                  rsp_load;
   logic                                  all_done;
   lane_stat_type [LANE_COUNT-1:0]        lane_stat;
   logic                                  merge_done;
   logic [SOL_W-1:0]                      merge_solution;
   logic                                  merge_solvable;

   assign req_xfer = req_tvalid & req_tready;

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < LANE_COUNT; i++) all_done = all_done & lane_stat[i].done;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE:  if (req_tvalid) state_in = T_COF;
         T_COF:   state_in = T_PROD;
         T_PROD:  state_in = T_LANES;
         T_LANES: state_in = T_WAIT;
         T_WAIT:  if (all_done) state_in = T_MERGE;
         T_MERGE: if (merge_done) state_in = T_OUT;
         T_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = (state_ff == T_IDLE);
      lane_start  = (state_ff == T_LANES);
      merge_start = (state_ff == T_WAIT) && all_done;
      rsp_load    = (state_ff == T_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   // cofactor of each lane is the product of the other two moduli
   always_comb begin
      cof_in[0] = COF_W'(mod_ff[1]) * COF_W'(mod_ff[2]);
      cof_in[1] = COF_W'(mod_ff[0]) * COF_W'(mod_ff[2]);
      cof_in[2] = COF_W'(mod_ff[0]) * COF_W'(mod_ff[1]);
      prod_in   = SOL_W'(cof_ff[2]) * SOL_W'(mod_ff[2]);
   end

   // output slot: hold until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = merge_solution;
         rsp_user_in  = merge_solvable;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int i = 0; i < LANE_COUNT; i++) begin
            res_ff[i] <= req_tdata[2*i*MOD_W +: MOD_W];
            mod_ff[i] <= req_tdata[(2*i+1)*MOD_W +: MOD_W];
         end
      end
      if (state_ff == T_COF) begin
         for (int i = 0; i < LANE_COUNT; i++) cof_ff[i] <= cof_in[i];
      end
      if (state_ff == T_PROD) prod_ff <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // one lane per congruence
   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      crt_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .start    (lane_start),
         .residue  (res_ff[g]),
         .modulus  (mod_ff[g]),
         .cofactor (cof_ff[g]),
         .status   (lane_stat[g])
      );
   end

   crt_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .start        (merge_start),
      .lanes        (lane_stat),
      .modulus_prod (prod_ff),
      .done         (merge_done),
      .solution     (merge_solution),
      .solvable     (merge_solvable)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
